[sv/polygon_edge_collision_check_unit_macros.svh]
// Assertion macros for the polygon edge collision check unit
`ifndef POLYGON_EDGE_COLLISION_CHECK_UNIT_MACROS_SVH
`define POLYGON_EDGE_COLLISION_CHECK_UNIT_MACROS_SVH
// implication checked each clock outside reset
`define PECC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PECC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/pecc_pkg.sv]
// ----------------------------------------------------------------------------
// pecc_pkg
// Shared types and constants of the polygon edge collision check unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pecc_pkg;
  localparam int unsigned MaxEdgesDef  = 16;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned InCoordW     = 16;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_CLOSE  = 3'd2,
    OP_POINT  = 3'd3,
    OP_SEG    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOPOLY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_LOAD,
    BS_CALC,
    BS_DONE
  } back_state_e;
endpackage
`default_nettype wire

[sv/pecc_front.sv]
// ----------------------------------------------------------------------------
// pecc_front
// Accepts items, sign-extends or truncates coordinates and queues them with the opcode.
// ----------------------------------------------------------------------------
`default_nettype none
module pecc_front #(
  parameter int unsigned CoordBits = pecc_pkg::CoordBitsDef,
  parameter int unsigned Depth     = pecc_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  opcode_i,
  input  wire logic [pecc_pkg::InCoordW-1:0] ax_i,
  input  wire logic [pecc_pkg::InCoordW-1:0] ay_i,
  input  wire logic [pecc_pkg::InCoordW-1:0] bx_i,
  input  wire logic [pecc_pkg::InCoordW-1:0] by_i,
  output logic                             q_valid_o,
  input  wire logic                        q_pop_i,
  output logic [2:0]                       q_op_o,
  output logic [4*CoordBits-1:0]           q_coord_o
);
  import pecc_pkg::*;
  localparam int unsigned W = 3 + 4*CoordBits;
  logic [W-1:0] mem_q [Depth];
  logic [$clog2(Depth)-1:0] wp_q, rp_q;
  logic [$clog2(Depth):0] cnt_q;
  logic push;
  logic [CoordBits-1:0] cax, cay, cbx, cby;

  function automatic logic [CoordBits-1:0] trim(input logic [InCoordW-1:0] v);
    logic [InCoordW+CoordBits-1:0] e;
    e = {{CoordBits{v[InCoordW-1]}}, v};
    return e[CoordBits-1:0];
  endfunction

  assign cax = trim(ax_i);
  assign cay = trim(ay_i);
  assign cbx = trim(bx_i);
  assign cby = trim(by_i);
  assign in_stall_o = (cnt_q == Depth[$clog2(Depth):0]);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign {q_op_o, q_coord_o} = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= {opcode_i, cax, cay, cbx, cby};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (q_pop_i && q_valid_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(Depth){1'b0}}, push}
                     - {{$clog2(Depth){1'b0}}, (q_pop_i && q_valid_o)};
    end
  end
endmodule
`default_nettype wire

[sv/pecc_back.sv]
// ----------------------------------------------------------------------------
// pecc_back
// Executes items: table update, and edge-by-edge query tests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_edge_collision_check_unit_macros.svh"
module pecc_back #(
  parameter int unsigned MaxEdges  = pecc_pkg::MaxEdgesDef,
  parameter int unsigned CoordBits = pecc_pkg::CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  output logic                       q_pop_o,
  input  wire logic [2:0]            q_op_i,
  input  wire logic [4*CoordBits-1:0] q_coord_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       collision_o,
  output logic [1:0]                 status_o,
  output logic [4:0]                 edges_held_o
);
  import pecc_pkg::*;
  localparam int unsigned IW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned CW = $clog2(MaxEdges + 1);
  localparam int unsigned C  = CoordBits;
  localparam int unsigned DW = C + 1;
  localparam int unsigned PW = 2*DW + 1;
  localparam int unsigned SW = PW + 2;
  localparam logic [CW-1:0] MaxC = CW'(MaxEdges);

  logic [4*C-1:0] tbl [MaxEdges];
  logic [CW-1:0] cnt_q, cnt_d;
  logic closed_q, closed_d;
  back_state_e st_q, st_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [4*C-1:0] rd_q, first_q, last_q;
  logic [2:0] op_q;
  logic signed [C-1:0] ax_q, ay_q, bx_q, by_q;
  logic hit_q, hit_d;
  logic ov_q, coll_q;
  logic [1:0] stat_q;
  logic wr_en;
  logic [IW-1:0] wr_a;
  logic [4*C-1:0] wr_dat;
  logic rd_en;
  logic [IW-1:0] rd_a;
  logic start, finish, fin_coll, needs_scan;
  logic [1:0] fin_stat;

  logic signed [C-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] edx, edy, qdx, qdy, wx, wy, pdy;
  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [SW-1:0] side, dd, tn, un;
  logic side_bad, crs, inbox_a, inbox_b, tok, uok;

  assign {sx, sy, ex, ey} = rd_q;
  assign edx = DW'(ex) - DW'(sx);
  assign edy = DW'(ey) - DW'(sy);
  assign qdx = DW'(bx_q) - DW'(ax_q);
  assign qdy = DW'(by_q) - DW'(ay_q);
  assign wx  = DW'(ax_q) - DW'(sx);
  assign wy  = DW'(ay_q) - DW'(sy);
  assign pdy = DW'(ay_q) - DW'(sy);
  // side = (py-sy)*edx - (px-sx)*edy, equal to the expanded form
  assign p1 = PW'(pdy) * PW'(edx);
  assign p2 = PW'(wx) * PW'(edy);
  assign p3 = PW'(edx) * PW'(qdy);
  assign p4 = PW'(edy) * PW'(qdx);
  assign p5 = PW'(wx) * PW'(qdy);
  assign p6 = PW'(wy) * PW'(qdx);
  assign side = SW'(p1) - SW'(p2);
  assign dd = SW'(p3) - SW'(p4);
  assign tn = SW'(p5) - SW'(p6);
  assign un = SW'(p2) - SW'(PW'(wy) * PW'(edx));
  assign side_bad = (side > 0);

  function automatic logic ratio(input logic signed [SW-1:0] n,
                                 input logic signed [SW-1:0] d);
    logic signed [SW:0] nn, dn;
    nn = d[SW-1] ? -(SW+1)'(n) : (SW+1)'(n);
    dn = d[SW-1] ? -(SW+1)'(d) : (SW+1)'(d);
    return (nn >= 0) && (nn <= dn);
  endfunction

  function automatic logic in_box(input logic signed [C-1:0] x0, y0, x1, y1, px, py);
    logic signed [C-1:0] xl, xh, yl, yh;
    xl = (x0 < x1) ? x0 : x1;
    xh = (x0 < x1) ? x1 : x0;
    yl = (y0 < y1) ? y0 : y1;
    yh = (y0 < y1) ? y1 : y0;
    return (px >= xl) && (px <= xh) && (py >= yl) && (py <= yh);
  endfunction

  assign tok = ratio(tn, dd);
  assign uok = ratio(un, dd);
  assign inbox_a = in_box(sx, sy, ex, ey, ax_q, ay_q);
  assign inbox_b = in_box(sx, sy, ex, ey, bx_q, by_q);
  assign crs = (dd != 0) ? (tok && uok) : (inbox_a || inbox_b);

  assign start = q_valid_i && (st_q == BS_IDLE) && (!ov_q || !out_stall_i);
  // point queries need a closed polygon, segment queries any stored edge
  assign needs_scan = (q_op_i == OP_POINT && closed_q) || (q_op_i == OP_SEG && cnt_q != '0);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BS_IDLE: if (start && needs_scan) st_d = BS_LOAD;
      BS_LOAD: st_d = BS_CALC;
      BS_CALC: if (idx_q == cnt_q || hit_d) st_d = BS_DONE;
      BS_DONE: if (!ov_q || !out_stall_i) st_d = BS_IDLE;
      default: st_d = BS_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    hit_d = hit_q;
    rd_en = 1'b0;
    rd_a = idx_q[IW-1:0];
    unique case (st_q)
      BS_IDLE: begin
        idx_d = '0;
        hit_d = 1'b0;
      end
      BS_LOAD: begin
        rd_en = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      BS_CALC: begin
        if (op_q == OP_POINT) hit_d = side_bad;
        else hit_d = crs;
        if (idx_q != cnt_q && !hit_d) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      BS_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    closed_d = closed_q;
    wr_en = 1'b0;
    wr_a = cnt_q[IW-1:0];
    wr_dat = q_coord_i;
    fin_coll = 1'b0;
    fin_stat = ST_OK;
    if (start) begin
      unique case (q_op_i)
        OP_CLEAR: begin
          cnt_d = '0;
          closed_d = 1'b0;
        end
        OP_APPEND: begin
          if (cnt_q >= MaxC) fin_stat = ST_FULL;
          else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_CLOSE: begin
          if (cnt_q == '0) fin_stat = ST_NOPOLY;
          else if (cnt_q >= MaxC) fin_stat = ST_FULL;
          else begin
            wr_en = 1'b1;
            wr_dat = {last_q[2*C-1:0], first_q[4*C-1:2*C]};
            cnt_d = cnt_q + 1'b1;
            closed_d = 1'b1;
          end
        end
        OP_POINT, OP_SEG: begin
          fin_coll = (q_op_i == OP_POINT);
          fin_stat = ST_NOPOLY;
        end
        default: ;
      endcase
    end
  end

  assign finish = (st_q == BS_DONE) && (!ov_q || !out_stall_i);
  assign q_pop_o = start;

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl[wr_a] <= wr_dat;
    if (rd_en) rd_q <= tbl[rd_a];
    if (wr_en) last_q <= wr_dat;
    if (wr_en && cnt_q == '0) first_q <= wr_dat;
    if (start) begin
      op_q <= q_op_i;
      {ax_q, ay_q, bx_q, by_q} <= q_coord_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BS_IDLE;
      cnt_q <= '0;
      closed_q <= 1'b0;
      idx_q <= '0;
      hit_q <= 1'b0;
      ov_q <= 1'b0;
      coll_q <= 1'b0;
      stat_q <= ST_OK;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      closed_q <= closed_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (start && !needs_scan) begin
        ov_q <= 1'b1;
        coll_q <= fin_coll;
        stat_q <= fin_stat;
      end else if (finish) begin
        ov_q <= 1'b1;
        coll_q <= (op_q == OP_POINT) ? !hit_q : hit_q;
        stat_q <= closed_q ? ST_OK : ST_NOPOLY;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign collision_o = coll_q;
  assign status_o = stat_q;
  assign edges_held_o = 5'(cnt_q);

  `PECC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= MaxC)
  `PECC_ASSERT_IMP(a_idx_range, st_q == BS_CALC, idx_q <= cnt_q)
  `PECC_ASSERT_NXT(a_done_out, finish, out_valid_o)
  `PECC_ASSERT_IMP(a_no_pop_busy, st_q != BS_IDLE, !q_pop_o)
endmodule
`default_nettype wire

[sv/polygon_edge_collision_check_unit.sv]
// ----------------------------------------------------------------------------
// polygon_edge_collision_check_unit
// Polygon edge table with point-in-polygon and segment crossing queries.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid_i/in_stall_o | opcode, first_x/y, second_x/y
// out     | out_valid_o/out_stall_i | collision, status, edges_held
// Table ops and queries answered without a scan execute as they are popped; a
// scanned query steps through load, one test per edge and done, stopping early on a
// hit, run by the single shared edge tester reading one entry per cycle.
// A 2-entry queue decouples input from execution; output is registered.
// Reset clears count and closed flag; table contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_edge_collision_check_unit #(
  parameter int unsigned MaxEdges  = pecc_pkg::MaxEdgesDef,
  parameter int unsigned CoordBits = pecc_pkg::CoordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [15:0] first_x_i,
  input  wire logic [15:0] first_y_i,
  input  wire logic [15:0] second_x_i,
  input  wire logic [15:0] second_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             collision_o,
  output logic [1:0]       status_o,
  output logic [4:0]       edges_held_o
);
  import pecc_pkg::*;
  logic q_valid, q_pop;
  logic [2:0] q_op;
  logic [4*CoordBits-1:0] q_coord;

  pecc_front #(.CoordBits(CoordBits), .Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .ax_i(first_x_i), .ay_i(first_y_i), .bx_i(second_x_i), .by_i(second_y_i),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_op_o(q_op), .q_coord_o(q_coord)
  );

  pecc_back #(.MaxEdges(MaxEdges), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_op_i(q_op),
    .q_coord_i(q_coord), .out_valid_o, .out_stall_i, .collision_o, .status_o,
    .edges_held_o
  );
endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the polygon edge collision check unit. Polygons
// are built, closed and queried with points and segments; every result is
// checked against a built-in model of the edge table and its geometry tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pecc_pkg::*;

  localparam int unsigned NumEdges  = 16;
  localparam int unsigned NumRandom = 1750;
  localparam longint      CycleCap  = 1000000;

  typedef struct {
    longint sx, sy, ex, ey;
  } edge_t;

  typedef struct {
    bit          hit;
    logic [1:0]  st;
    logic [4:0]  held;
  } verdict_t;

  int unsigned mismatches = 0;

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  class collision_scoreboard;
    edge_t       edges[NumEdges];
    int unsigned count;
    bit          closed;
    verdict_t    pending[$];

    function void clear_state();
      count  = 0;
      closed = 0;
    endfunction

    function automatic bit in_box(edge_t g, longint x, longint y);
      longint xlo, xhi, ylo, yhi;
      xlo = (g.sx < g.ex) ? g.sx : g.ex;
      xhi = (g.sx < g.ex) ? g.ex : g.sx;
      ylo = (g.sy < g.ey) ? g.sy : g.ey;
      yhi = (g.sy < g.ey) ? g.ey : g.sy;
      return x >= xlo && x <= xhi && y >= ylo && y <= yhi;
    endfunction

    function automatic bit ratio_ok(longint n, longint d);
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      return n >= 0 && n <= d;
    endfunction

    function automatic bit seg_hits(edge_t g, longint ax, longint ay, longint bx,
                                    longint by);
      longint edx, edy, qdx, qdy, d, wx, wy;
      edx = g.ex - g.sx;
      edy = g.ey - g.sy;
      qdx = bx - ax;
      qdy = by - ay;
      d   = edx * qdy - edy * qdx;
      if (d != 0) begin
        wx = ax - g.sx;
        wy = ay - g.sy;
        return ratio_ok(wx * qdy - wy * qdx, d) && ratio_ok(wx * edy - wy * edx, d);
      end
      return in_box(g, ax, ay) || in_box(g, bx, by);
    endfunction

    function void note_item(logic [2:0] op, logic signed [15:0] fx,
                            logic signed [15:0] fy, logic signed [15:0] sx,
                            logic signed [15:0] sy);
      verdict_t v;
      longint   side;
      v.hit = 0;
      v.st  = ST_OK;
      case (op)
        OP_CLEAR: clear_state();
        OP_APPEND: begin
          if (count >= NumEdges) v.st = ST_FULL;
          else begin
            edges[count] = '{fx, fy, sx, sy};
            count++;
          end
        end
        OP_CLOSE: begin
          if (count == 0) v.st = ST_NOPOLY;
          else if (count >= NumEdges) v.st = ST_FULL;
          else begin
            edges[count] = '{edges[count-1].ex, edges[count-1].ey,
                             edges[0].sx, edges[0].sy};
            count++;
            closed = 1;
          end
        end
        OP_POINT: begin
          v.hit = 1;
          if (!closed || count == 0) v.st = ST_NOPOLY;
          else
            for (int i = 0; i < count; i++) begin
              side = longint'(fy) * (edges[i].ex - edges[i].sx)
                   - longint'(fx) * (edges[i].ey - edges[i].sy)
                   + edges[i].sx * edges[i].ey - edges[i].ex * edges[i].sy;
              if (side > 0) begin
                v.hit = 0;
                break;
              end
            end
        end
        OP_SEG: begin
          if (!closed || count == 0) v.st = ST_NOPOLY;
          for (int i = 0; i < count; i++)
            if (seg_hits(edges[i], fx, fy, sx, sy)) begin
              v.hit = 1;
              break;
            end
        end
        default: ;
      endcase
      v.held = count[4:0];
      pending = {pending, v};
    endfunction

    task check_result(logic hit, logic [1:0] st, logic [4:0] held);
      verdict_t v;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      v = pending.pop_front();
      if (hit !== v.hit) report("collision", hit, v.hit);
      if (st !== v.st) report("status", st, v.st);
      if (held !== v.held) report("edges_held", held, v.held);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic [2:0]  opcode_i = '0;
  logic [15:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic        out_stall_i = 0;
  logic        in_stall_o, out_valid_o, collision_o;
  logic [1:0]  status_o;
  logic [4:0]  edges_held_o;

  collision_scoreboard board = new();
  longint cycles = 0;
  int unsigned items_sent = 0, results_seen = 0, hits_seen = 0;

  polygon_edge_collision_check_unit u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input logic [2:0] op, input logic [15:0] fx, input logic [15:0] fy,
                      input logic [15:0] sx, input logic [15:0] sy);
    in_valid_i <= 1;
    opcode_i   <= op;
    first_x_i  <= fx;
    first_y_i  <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(op, fx, fy, sx, sy);
    items_sent++;
  endtask

  task automatic send_gapped(input logic [2:0] op, input logic [15:0] fx,
                             input logic [15:0] fy, input logic [15:0] sx,
                             input logic [15:0] sy, input bit calm);
    int unsigned g;
    send(op, fx, fy, sx, sy);
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rnd_coord(int unsigned span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 2 * span)) - $signed(span));
  endfunction

  // random convex-ish polygon around the origin, built counter-clockwise
  task automatic build_polygon(input int unsigned n, input int unsigned span, input bit calm);
    logic [15:0] px[NumEdges+1], py[NumEdges+1];
    for (int i = 0; i < n; i++) begin
      int a;
      a = i * 360 / n;
      px[i] = 16'(int'($cos(a * 3.14159265 / 180.0) * span));
      py[i] = 16'(int'($sin(a * 3.14159265 / 180.0) * span));
    end
    send_gapped(OP_CLEAR, rnd_coord(9), rnd_coord(9), 0, 0, calm);
    for (int i = 0; i + 1 < n; i++)
      send_gapped(OP_APPEND, px[i], py[i], px[i+1], py[i+1], calm);
    send_gapped(OP_CLOSE, 0, 0, 0, 0, calm);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(collision_o, status_o, edges_held_o);
      results_seen <= results_seen + 1;
      hits_seen <= hits_seen + collision_o;
    end
    if (cycles > CycleCap) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result-side stall, with quiet stretches
  initial begin
    int unsigned g;
    out_stall_i <= 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1;
          repeat (g) @(posedge clk_i);
          out_stall_i <= 0;
        end
      end else if ($urandom_range(0, 199) == 0) begin
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned sent, sel, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table cases, extremes, full table, double close
    send_gapped(OP_POINT, 16'h8000, 16'h7fff, 0, 0, 1);
    send_gapped(OP_SEG, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1);
    send_gapped(OP_CLOSE, 0, 0, 0, 0, 1);
    send_gapped(OP_APPEND, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 0);
    send_gapped(OP_SEG, 0, 16'h8000, 0, 16'h7fff, 0);
    send_gapped(OP_POINT, 0, 0, 0, 0, 0);
    send_gapped(OP_APPEND, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 0);
    send_gapped(OP_APPEND, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_gapped(OP_CLOSE, 0, 0, 0, 0, 0);
    send_gapped(OP_POINT, 0, 0, 16'hffff, 16'hffff, 0);
    send_gapped(OP_POINT, 16'h8000, 16'h8000, 0, 0, 0);
    send_gapped(OP_SEG, 5, 5, 5, 5, 0);
    send_gapped(OP_SEG, 16'h8000, 16'h8000, 16'h8001, 16'h8000, 0);
    send_gapped(OP_APPEND, 1, 2, 3, 4, 0);
    send_gapped(OP_CLOSE, 0, 0, 0, 0, 0);
    send_gapped(3'd5, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_gapped(3'd7, 0, 0, 0, 0, 0);
    for (int i = 0; i < 12; i++)
      send_gapped(OP_APPEND, 16'(i), 16'(-i), 16'(i + 1), 16'(i * 3), 1);
    send_gapped(OP_APPEND, 1, 1, 1, 1, 1);
    send_gapped(OP_CLOSE, 0, 0, 0, 0, 1);
    send_gapped(OP_POINT, 0, 0, 0, 0, 1);
    send_gapped(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);

    // random: mostly closed polygons with queries, some noise
    sent = 0;
    while (sent < NumRandom) begin
      bit calm;
      calm = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      n = $urandom_range(3, (sel == 0) ? 17 : 8);
      if (sel < 8) begin
        build_polygon(n, (sel < 6) ? $urandom_range(4, 200) : $urandom_range(1000, 32000),
                      calm);
        sent += n + 1;
        repeat ($urandom_range(2, 10)) begin
          logic [15:0] ax, ay;
          ax = rnd_coord(300);
          ay = rnd_coord(300);
          if ($urandom_range(0, 1))
            send_gapped(OP_POINT, ax, ay, 16'($urandom), 16'($urandom), calm);
          else if ($urandom_range(0, 3) == 0)
            send_gapped(OP_SEG, ax, ay, ax, ay, calm);
          else
            send_gapped(OP_SEG, ax, ay, rnd_coord(300), rnd_coord(300), calm);
          sent++;
        end
      end else begin
        repeat ($urandom_range(5, 20)) begin
          send_gapped(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), calm);
          sent++;
        end
      end
    end
    in_valid_i <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d items; checked %0d results, %0d with a collision.",
             items_sent, results_seen, hits_seen);
    if (mismatches == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/pecc_pkg.sv
sv/pecc_front.sv
sv/pecc_back.sv
sv/polygon_edge_collision_check_unit.sv
verif/tb_top.sv
